FILE: design/premultiplied_alpha_resample_accum_unit_defines.svh
// assertion macros for the resample accumulator checker
`ifndef PREMULTIPLIED_ALPHA_RESAMPLE_ACCUM_UNIT_DEFINES_SVH
`define PREMULTIPLIED_ALPHA_RESAMPLE_ACCUM_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define PARA_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, checked outside reset
`define PARA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: design/pmara_pkg.sv
// shared types and constants of the resample accumulator
package pmara_pkg;

    localparam int COLOR_SUM_W  = 48;
    localparam int ALPHA_SUM_W  = 40;
    localparam int WEIGHT_SUM_W = 32;
    localparam int WA_W         = 25;
    localparam int PROD_W       = 34;
    localparam int DIV_STEPS    = 8;
    localparam int STEP_W       = 3;
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DIV_STEPS - 1);
    localparam logic [1:0] SEL_LAST = 2'd3;

    typedef struct packed {
        logic [7:0]         src_red;
        logic [7:0]         src_green;
        logic [7:0]         src_blue;
        logic [7:0]         src_alpha;
        logic signed [15:0] tap_weight;
        logic               last_tap;
    } pix_in_t;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic [7:0] out_alpha;
    } pix_out_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_A,
        ST_MUL_C,
        ST_ACCUM,
        ST_DIV_LOAD,
        ST_DIV_CHECK,
        ST_DIV_STEP,
        ST_DIV_ROUND,
        ST_HOLD
    } pmara_state_t;

    typedef enum logic [1:0] {
        FORCE_NONE,
        FORCE_ZERO,
        FORCE_MAX
    } pmara_force_t;

    typedef struct packed {
        logic       load_in;
        logic       mul_a;
        logic       mul_c;
        logic       accum;
        logic       div_load;
        logic       div_check;
        logic       div_step;
        logic       div_round;
        logic [1:0] div_sel;
        logic       out_load;
        logic       clear_sums;
    } pmara_cmd_t;

    typedef struct packed {
        logic last_tap;
    } pmara_status_t;

endpackage

FILE: design/pmara_dp.sv
// datapath: products, saturating sums and the shared serial divider
module pmara_dp (
    input  logic                   aclk,
    input  pmara_pkg::pix_in_t     in_data,
    input  pmara_pkg::pmara_cmd_t  cmd,
    output pmara_pkg::pmara_status_t status,
    output pmara_pkg::pix_out_t    out_data
);

    pmara_pkg::pix_in_t in_reg;
    logic signed [pmara_pkg::WA_W-1:0]   wa_reg;
    logic signed [pmara_pkg::PROD_W-1:0] pr_reg, pg_reg, pb_reg;
    logic signed [pmara_pkg::COLOR_SUM_W-1:0]  red_sum_reg, green_sum_reg, blue_sum_reg;
    logic signed [pmara_pkg::ALPHA_SUM_W-1:0]  alpha_sum_reg;
    logic signed [pmara_pkg::WEIGHT_SUM_W-1:0] weight_sum_reg;

    logic [47:0] num_mag_reg;
    logic [39:0] den_mag_reg;
    logic [47:0] rem_reg;
    logic [47:0] dsh_reg;
    logic [7:0]  q_reg;
    pmara_pkg::pmara_force_t force_reg;
    logic [7:0]  res_reg [4];
    pmara_pkg::pix_out_t out_reg;

    logic signed [48:0] red_next, green_next, blue_next;
    logic signed [40:0] alpha_next;
    logic signed [32:0] weight_next;
    logic signed [48:0] div_num;
    logic signed [40:0] div_den;
    logic signed [48:0] nn;
    logic signed [40:0] dn;
    pmara_pkg::pmara_force_t force_next;
    logic [48:0] lim;
    logic [48:0] twice_rem;
    logic        round_up;
    logic [7:0]  res_next;

    localparam logic signed [48:0] C_HI = 49'sh0_7FFF_FFFF_FFFF;
    localparam logic signed [48:0] C_LO = -C_HI - 49'sd1;
    localparam logic signed [40:0] A_HI = 41'sh0_7F_FFFF_FFFF;
    localparam logic signed [40:0] A_LO = -A_HI - 41'sd1;
    localparam logic signed [32:0] W_HI = 33'sh0_7FFF_FFFF;
    localparam logic signed [32:0] W_LO = -W_HI - 33'sd1;

    assign status.last_tap = in_reg.last_tap;
    assign out_data = out_reg;

    always_comb begin
        red_next    = 49'(red_sum_reg) + 49'(pr_reg);
        green_next  = 49'(green_sum_reg) + 49'(pg_reg);
        blue_next   = 49'(blue_sum_reg) + 49'(pb_reg);
        alpha_next  = 41'(alpha_sum_reg) + 41'(wa_reg);
        weight_next = 33'(weight_sum_reg) + 33'(in_reg.tap_weight);
    end

    // operand select and sign normalization
    always_comb begin
        if (cmd.div_sel == pmara_pkg::SEL_LAST) begin
            div_num = 49'(alpha_sum_reg);
            div_den = 41'(weight_sum_reg);
        end else begin
            div_den = 41'(alpha_sum_reg);
            case (cmd.div_sel)
                2'd0:    div_num = 49'(red_sum_reg);
                2'd1:    div_num = 49'(green_sum_reg);
                default: div_num = 49'(blue_sum_reg);
            endcase
        end
        nn = (div_den < 0) ? -div_num : div_num;
        dn = (div_den < 0) ? -div_den : div_den;
        if (div_den == 41'sd0) begin
            force_next = (div_num > 0) ? pmara_pkg::FORCE_MAX : pmara_pkg::FORCE_ZERO;
        end else if (nn <= 0) begin
            force_next = pmara_pkg::FORCE_ZERO;
        end else begin
            force_next = pmara_pkg::FORCE_NONE;
        end
    end

    always_comb begin
        lim       = {1'b0, den_mag_reg, 8'b0} - {9'b0, den_mag_reg};
        twice_rem = {rem_reg, 1'b0};
        round_up  = (twice_rem > {9'b0, den_mag_reg})
                 || ((twice_rem == {9'b0, den_mag_reg}) && q_reg[0]);
        case (force_reg)
            pmara_pkg::FORCE_NONE: res_next = q_reg + {7'b0, round_up};
            pmara_pkg::FORCE_MAX:  res_next = 8'hFF;
            default:               res_next = 8'h00;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            in_reg <= in_data;
        end
        if (cmd.mul_a) begin
            wa_reg <= in_reg.tap_weight * $signed({1'b0, in_reg.src_alpha});
        end
        if (cmd.mul_c) begin
            pr_reg <= wa_reg * $signed({1'b0, in_reg.src_red});
            pg_reg <= wa_reg * $signed({1'b0, in_reg.src_green});
            pb_reg <= wa_reg * $signed({1'b0, in_reg.src_blue});
        end
        if (cmd.clear_sums) begin
            red_sum_reg    <= '0;
            green_sum_reg  <= '0;
            blue_sum_reg   <= '0;
            alpha_sum_reg  <= '0;
            weight_sum_reg <= '0;
        end else if (cmd.accum) begin
            red_sum_reg <= (red_next > C_HI) ? C_HI[47:0] :
                           (red_next < C_LO) ? C_LO[47:0] : red_next[47:0];
            green_sum_reg <= (green_next > C_HI) ? C_HI[47:0] :
                             (green_next < C_LO) ? C_LO[47:0] : green_next[47:0];
            blue_sum_reg <= (blue_next > C_HI) ? C_HI[47:0] :
                            (blue_next < C_LO) ? C_LO[47:0] : blue_next[47:0];
            alpha_sum_reg <= (alpha_next > A_HI) ? A_HI[39:0] :
                             (alpha_next < A_LO) ? A_LO[39:0] : alpha_next[39:0];
            weight_sum_reg <= (weight_next > W_HI) ? W_HI[31:0] :
                              (weight_next < W_LO) ? W_LO[31:0] : weight_next[31:0];
        end
        if (cmd.div_load) begin
            num_mag_reg <= nn[47:0];
            den_mag_reg <= dn[39:0];
            force_reg   <= force_next;
        end
        if (cmd.div_check) begin
            // quotient of 255 or more saturates
            if (force_reg == pmara_pkg::FORCE_NONE && {1'b0, num_mag_reg} >= lim) begin
                force_reg <= pmara_pkg::FORCE_MAX;
            end
            rem_reg <= num_mag_reg;
            dsh_reg <= {1'b0, den_mag_reg, 7'b0};
            q_reg   <= '0;
        end
        if (cmd.div_step) begin
            if (rem_reg >= dsh_reg) begin
                rem_reg <= rem_reg - dsh_reg;
                q_reg   <= {q_reg[6:0], 1'b1};
            end else begin
                q_reg   <= {q_reg[6:0], 1'b0};
            end
            dsh_reg <= {1'b0, dsh_reg[47:1]};
        end
        if (cmd.div_round) begin
            res_reg[cmd.div_sel] <= res_next;
        end
        if (cmd.out_load) begin
            out_reg.out_red   <= res_reg[0];
            out_reg.out_green <= res_reg[1];
            out_reg.out_blue  <= res_reg[2];
            out_reg.out_alpha <= res_reg[3];
        end
    end

endmodule

FILE: design/pmara_ctrl.sv
// controller: sequences accumulation, four divisions and the result handshake
module pmara_ctrl (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    output logic                    m_valid,
    input  logic                    m_ready,
    input  pmara_pkg::pmara_status_t status,
    output pmara_pkg::pmara_cmd_t   cmd
);

    pmara_pkg::pmara_state_t state_reg, state_next;
    logic [1:0] sel_reg, sel_next;
    logic [pmara_pkg::STEP_W-1:0] step_reg, step_next;
    logic m_valid_reg, m_valid_next;
    logic out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign s_ready  = (state_reg == pmara_pkg::ST_IDLE);

    always_comb begin
        state_next = state_reg;
        sel_next   = sel_reg;
        step_next  = step_reg;
        case (state_reg)
            pmara_pkg::ST_IDLE: begin
                if (s_valid) state_next = pmara_pkg::ST_MUL_A;
            end
            pmara_pkg::ST_MUL_A: state_next = pmara_pkg::ST_MUL_C;
            pmara_pkg::ST_MUL_C: state_next = pmara_pkg::ST_ACCUM;
            pmara_pkg::ST_ACCUM: begin
                sel_next   = '0;
                state_next = status.last_tap ? pmara_pkg::ST_DIV_LOAD : pmara_pkg::ST_IDLE;
            end
            pmara_pkg::ST_DIV_LOAD: state_next = pmara_pkg::ST_DIV_CHECK;
            pmara_pkg::ST_DIV_CHECK: begin
                step_next  = '0;
                state_next = pmara_pkg::ST_DIV_STEP;
            end
            pmara_pkg::ST_DIV_STEP: begin
                step_next = step_reg + 1'b1;
                if (step_reg == pmara_pkg::STEP_LAST) state_next = pmara_pkg::ST_DIV_ROUND;
            end
            pmara_pkg::ST_DIV_ROUND: begin
                if (sel_reg == pmara_pkg::SEL_LAST) begin
                    state_next = pmara_pkg::ST_HOLD;
                end else begin
                    sel_next   = sel_reg + 1'b1;
                    state_next = pmara_pkg::ST_DIV_LOAD;
                end
            end
            pmara_pkg::ST_HOLD: begin
                if (out_free) state_next = pmara_pkg::ST_IDLE;
            end
            default: state_next = pmara_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd            = '0;
        cmd.div_sel    = sel_reg;
        cmd.load_in    = (state_reg == pmara_pkg::ST_IDLE) && s_valid;
        cmd.mul_a      = (state_reg == pmara_pkg::ST_MUL_A);
        cmd.mul_c      = (state_reg == pmara_pkg::ST_MUL_C);
        cmd.accum      = (state_reg == pmara_pkg::ST_ACCUM);
        cmd.div_load   = (state_reg == pmara_pkg::ST_DIV_LOAD);
        cmd.div_check  = (state_reg == pmara_pkg::ST_DIV_CHECK);
        cmd.div_step   = (state_reg == pmara_pkg::ST_DIV_STEP);
        cmd.div_round  = (state_reg == pmara_pkg::ST_DIV_ROUND);
        cmd.out_load   = (state_reg == pmara_pkg::ST_HOLD) && out_free;
        // sums clear after each pixel and while reset is held
        cmd.clear_sums = cmd.out_load || !aresetn;
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) m_valid_next = 1'b0;
        if (cmd.out_load) m_valid_next = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= pmara_pkg::ST_IDLE;
            sel_reg     <= '0;
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            sel_reg     <= sel_next;
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

FILE: design/premultiplied_alpha_resample_accum_unit.sv
// Resampling accumulator for straight-alpha RGBA taps with premultiplied sums.
// Input channel s_: one tap per transfer (color, alpha, signed weight with
// 14 fraction bits, last-tap mark). Result channel m_: one RGBA pixel per run.
// Each tap passes from transfer to the next s_ready through a weight*alpha
// multiply, three color multiplies, then the saturating sum update.
// On the last tap the sums feed one shared restoring divider that produces one
// quotient bit a cycle: per channel a load, a saturation check, 8 steps and a
// rounding step for each of the four quotients in turn, then the pixel is
// loaded into the output register.
// The output register frees the divider: while a pixel waits for m_ready the
// block keeps accepting taps; only a following last tap waits for the output
// register to empty before its pixel is loaded and its sums are cleared.
// Reset (aresetn low, synchronous) returns the controller to idle, drops
// m_valid and clears all sums; the sums are also cleared after each pixel.
module premultiplied_alpha_resample_accum_unit (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  pmara_pkg::pix_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output pmara_pkg::pix_out_t m_data
);

    pmara_pkg::pmara_cmd_t    cmd;
    pmara_pkg::pmara_status_t status;

    pmara_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    pmara_dp u_dp (
        .aclk     (aclk),
        .in_data  (s_data),
        .cmd      (cmd),
        .status   (status),
        .out_data (m_data)
    );

endmodule

FILE: design/pmara_checker.sv
// port-level checker for the resample accumulator, bound to the top level
`include "premultiplied_alpha_resample_accum_unit_defines.svh"

module pmara_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input pmara_pkg::pix_out_t m_data
);

    // a pending result holds until taken
    `PARA_ASSERT_NEXT(a_m_hold, m_valid && !m_ready, m_valid && $stable(m_data))
    // a tap keeps the block busy for the following cycle
    `PARA_ASSERT_NEXT(a_busy_after_tap, s_valid && s_ready, !s_ready)
    // a new result never appears in the cycle after a tap transfer
    `PARA_ASSERT_NEXT(a_no_instant_result, s_valid && s_ready && !m_valid, !m_valid)
    // the block is ready right after reset
    `PARA_ASSERT_NOW(a_ready_out_of_reset, $rose(aresetn), s_ready && !m_valid)

endmodule

bind premultiplied_alpha_resample_accum_unit pmara_checker u_pmara_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
